[rtl/cs_pkg.sv]
// Package for the counting sort block.
// Holds the sequencer state type that the top level uses; no dependencies.
package cs_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,      // sweep the bin memory to zero after reset
      ST_LOAD,       // take values and count them into their bins
      ST_DRAIN,      // let the last histogram write land before the scan
      ST_SCAN_RD,    // issue the read of the bin under the scan pointer
      ST_SCAN_CHK,   // look at the bin count, zero the bin if it holds values
      ST_SCAN_EMIT   // hand out the bin value once per count
   } cs_state_type;

endpackage

[rtl/counting_sort.sv]
// Counting sort top level: histogram memory, load pipeline and output scan.
// Depends on cs_pkg for the sequencer state type.
//
// The block sorts sets of signed values by counting them into one bin per
// value in a single-port-write, registered-read memory. While loading it takes
// one value per cycle; a read-modify-write pipeline with forwarding from the
// previous write lets back-to-back values hit the same bin. The value sent
// with req_tlast closes the set: after a drain state the block walks the
// bins from the set's minimum to its maximum, reading and checking each bin
// in that range and emitting each result it hands out, and it takes
// no input until the final result (marked by rsp_tlast) is in the output
// register. Each bin is zeroed as it is read, so the memory is clean for the
// next set. At most MAX_ITEMS values are counted per set; later values are
// dropped and rsp_tuser is set on the final result. After reset a clearing
// pass zeroes every bin of the memory before req_tready rises.
module counting_sort
   import cs_pkg::*;
#(
   parameter int VALUE_BITS = 11,
   parameter int MAX_ITEMS  = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_value
   input  logic                                 req_tlast,  // end_of_set
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((VALUE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // sorted_value
   output logic                                 rsp_tlast,  // final_flag
   output logic                                 rsp_tuser   // overflow_flag
);

   localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int BIN_DEPTH = 1 << VALUE_BITS;
   localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

   logic [CNT_BITS-1:0] bin_mem [BIN_DEPTH];

   cs_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]        clr_addr_ff, clr_addr_in;
   logic [VALUE_BITS-1:0]        scan_addr_ff, scan_addr_in;
   logic signed [VALUE_BITS-1:0] low_ff, low_in;
   logic signed [VALUE_BITS-1:0] high_ff, high_in;
   logic [CNT_BITS-1:0]          loaded_ff, loaded_in;
   logic                         dropped_ff, dropped_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0]        s1_addr_ff, s1_addr_in;
   logic                         last_wr_valid_ff;
   logic [VALUE_BITS-1:0]        last_wr_addr_ff;
   logic [CNT_BITS-1:0]          last_wr_data_ff;
   logic [CNT_BITS-1:0]          rd_data_ff;
   logic [CNT_BITS-1:0]          remaining_ff, remaining_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]        rsp_value_ff, rsp_value_in;
   logic                         rsp_final_ff, rsp_final_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic                         accept;
   logic                         load_ok;
   logic signed [VALUE_BITS-1:0] sample;
   logic [CNT_BITS-1:0]          cur_count;
   logic                         mem_we;
   logic [VALUE_BITS-1:0]        mem_waddr;
   logic [CNT_BITS-1:0]          mem_wdata;
   logic [VALUE_BITS-1:0]        mem_raddr;
   logic                         out_free;
   logic                         at_high;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign sample     = $signed(req_tdata[VALUE_BITS-1:0]);
   assign load_ok    = (loaded_ff < CNT_BITS'(MAX_ITEMS));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign at_high    = (scan_addr_ff == VALUE_BITS'(high_ff));

   // Forward the write made last cycle: the read for this bin was taken at
   // the same edge and missed it.
   assign cur_count = (last_wr_valid_ff && (last_wr_addr_ff == s1_addr_ff)) ?
                      last_wr_data_ff : rd_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      scan_addr_in = scan_addr_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      loaded_in    = loaded_ff;
      dropped_in   = dropped_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = req_tdata[VALUE_BITS-1:0];
      remaining_in = remaining_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      mem_waddr    = s1_addr_ff;
      mem_wdata    = cur_count + CNT_BITS'(1);
      mem_raddr    = req_tdata[VALUE_BITS-1:0];

      // Histogram write-back of the value accepted last cycle
      if (s1_valid_ff) begin
         mem_we = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + VALUE_BITS'(1);
            if (clr_addr_ff == {VALUE_BITS{1'b1}}) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (accept) begin
               if (load_ok) begin
                  s1_valid_in = 1'b1;
                  loaded_in   = loaded_ff + CNT_BITS'(1);
                  if (loaded_ff == '0 || sample < low_ff) begin
                     low_in = sample;
                  end
                  if (loaded_ff == '0 || sample > high_ff) begin
                     high_in = sample;
                  end
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            scan_addr_in = VALUE_BITS'(low_ff);
            state_in     = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            mem_raddr = scan_addr_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff == '0) begin
               scan_addr_in = scan_addr_ff + VALUE_BITS'(1);
               state_in     = ST_SCAN_RD;
            end else begin
               // Empty the bin now; the count is held in remaining_ff
               mem_we       = 1'b1;
               mem_waddr    = scan_addr_ff;
               mem_wdata    = '0;
               remaining_in = rd_data_ff;
               state_in     = ST_SCAN_EMIT;
            end
         end
         ST_SCAN_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = scan_addr_ff;
               rsp_final_in = at_high && (remaining_ff == CNT_BITS'(1));
               rsp_ovf_in   = at_high && (remaining_ff == CNT_BITS'(1)) && dropped_ff;
               remaining_in = remaining_ff - CNT_BITS'(1);
               if (remaining_ff == CNT_BITS'(1)) begin
                  if (at_high) begin
                     low_in     = '0;
                     high_in    = '0;
                     loaded_in  = '0;
                     dropped_in = 1'b0;
                     state_in   = ST_LOAD;
                  end else begin
                     scan_addr_in = scan_addr_ff + VALUE_BITS'(1);
                     state_in     = ST_SCAN_RD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bin_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         low_ff           <= '0;
         high_ff          <= '0;
         loaded_ff        <= '0;
         dropped_ff       <= 1'b0;
         s1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         low_ff           <= low_in;
         high_ff          <= high_in;
         loaded_ff        <= loaded_in;
         dropped_ff       <= dropped_in;
         s1_valid_ff      <= s1_valid_in;
         last_wr_valid_ff <= s1_valid_ff;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff    <= scan_addr_in;
      s1_addr_ff      <= s1_addr_in;
      last_wr_addr_ff <= s1_addr_ff;
      last_wr_data_ff <= cur_count + CNT_BITS'(1);
      remaining_ff    <= remaining_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_final_ff    <= rsp_final_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_value_ff);
   assign rsp_tlast  = rsp_final_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

[rtl/cs_checker.sv]
// Port-level checker for the counting sort block, bound to counting_sort.
// Watches only the top-level ports; no package dependencies.
module cs_checker #(
   parameter int VALUE_BITS = 11
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((VALUE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   input logic                                 rsp_tlast,
   input logic                                 rsp_tuser
);

   logic                         mid_set_ff;
   logic signed [VALUE_BITS-1:0] prev_value_ff;
   logic                         out_xfer;
   logic signed [VALUE_BITS-1:0] out_value;

   assign out_xfer  = rsp_tvalid && rsp_tready;
   assign out_value = $signed(rsp_tdata[VALUE_BITS-1:0]);

   // Track the previous result of the set in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_set_ff <= 1'b0;
      end else if (out_xfer) begin
         mid_set_ff <= !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (out_xfer) begin
         prev_value_ff <= out_value;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_clear_blocks_input: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input ready before the clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      out_xfer && mid_set_ff |-> out_value >= prev_value_ff)
      else $error("results out of ascending order");

   a_overflow_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("overflow flag on a result that is not the last of its set");

endmodule

bind counting_sort cs_checker #(.VALUE_BITS(VALUE_BITS)) u_cs_checker (.*);
